// ===== rtl/tga_rle_image_decoder_macros.svh =====
// assertion helpers shared by the decoder modules
// each use expects clk and rst_n in scope
`ifndef TGA_RLE_IMAGE_DECODER_MACROS_SVH
`define TGA_RLE_IMAGE_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define TGARD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TGARD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TGARD_CHECK(lbl, prop, msg)
`define TGARD_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/tgard_pkg.sv =====
`timescale 1ns / 1ps

package tgard_pkg;

  // result kinds
  localparam logic [1:0] KIND_PIXEL     = 2'd0;
  localparam logic [1:0] KIND_HEADER    = 2'd1;
  localparam logic [1:0] KIND_BAD_TYPE  = 2'd2;
  localparam logic [1:0] KIND_BAD_DEPTH = 2'd3;

  // header layout
  localparam logic [4:0] HDR_SIG_BYTES   = 5'd12;
  localparam logic [4:0] HDR_TYPE_INDEX  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO    = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI    = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO   = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI   = 5'd15;
  localparam logic [4:0] HDR_DEPTH_INDEX = 5'd16;
  localparam logic [4:0] HDR_LAST_INDEX  = 5'd17;

  localparam logic [7:0] TYPE_PLAIN = 8'h02;
  localparam logic [7:0] TYPE_RLE   = 8'h0A;
  localparam logic [7:0] DEPTH_24   = 8'd24;
  localparam logic [7:0] DEPTH_32   = 8'd32;
  localparam logic [7:0] RUN_FLAG   = 8'd128;
  localparam logic [7:0] RUN_BIAS   = 8'd127;

  localparam int QUEUE_DEPTH = 2;
  localparam int PROD_BITS   = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  bits_per_pixel;
    logic        last;
  } item_t;

endpackage

// ===== rtl/tgard_front.sv =====
`timescale 1ns / 1ps
`include "tga_rle_image_decoder_macros.svh"

module tgard_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  input  logic              q_full,
  output logic              push,
  output tgard_pkg::item_t  push_item
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PKT_HEAD,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt, cur_phase;
  logic [4:0]  idx_r, idx_nxt, cur_idx;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic        plain_r, plain_nxt, cur_plain;
  logic        rle_r, rle_nxt, cur_rle;
  logic [7:0]  left_r, left_nxt;
  logic        is_run_r, is_run_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [15:0] col_r, col_nxt;
  logic [1:0]  pad_r, pad_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        is_32;
  logic        pix_done;
  logic [15:0] col_inc;
  logic [7:0]  left_dec;
  logic [7:0]  sig_plain;
  logic [7:0]  sig_rle;
  logic        bad_type;
  logic        bad_depth;
  logic        empty_img;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data_byte;
  assign is_32    = (depth_r == tgard_pkg::DEPTH_32);
  assign pix_done = is_32 ? (bip_r == 2'd3) : (bip_r == 2'd2);
  assign col_inc  = col_r + 16'd1;
  assign left_dec = left_r - 8'd1;

  // a first byte restarts parsing on this very byte
  assign cur_phase = in_first_byte ? PH_HEADER : phase_r;
  assign cur_idx   = in_first_byte ? 5'd0 : idx_r;
  assign cur_plain = in_first_byte ? 1'b1 : plain_r;
  assign cur_rle   = in_first_byte ? 1'b1 : rle_r;

  assign sig_plain = (cur_idx == tgard_pkg::HDR_TYPE_INDEX) ? tgard_pkg::TYPE_PLAIN : 8'd0;
  assign sig_rle   = (cur_idx == tgard_pkg::HDR_TYPE_INDEX) ? tgard_pkg::TYPE_RLE : 8'd0;
  assign bad_type  = !cur_plain && !cur_rle;
  assign bad_depth = (depth_r != tgard_pkg::DEPTH_24) && (depth_r != tgard_pkg::DEPTH_32);
  assign empty_img = (width_r == 16'd0) || (height_r == 16'd0);

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    plain_nxt  = plain_r;
    rle_nxt    = rle_r;
    left_nxt   = left_r;
    is_run_nxt = is_run_r;
    asm_nxt    = asm_r;
    bip_nxt    = bip_r;
    col_nxt    = col_r;
    pad_nxt    = pad_r;
    push       = 1'b0;
    push_item  = '0;
    if (accept) begin
      if (in_first_byte) begin
        phase_nxt  = PH_HEADER;
        idx_nxt    = 5'd0;
        plain_nxt  = 1'b1;
        rle_nxt    = 1'b1;
        left_nxt   = 8'd0;
        is_run_nxt = 1'b0;
        asm_nxt    = 24'd0;
        bip_nxt    = 2'd0;
        col_nxt    = 16'd0;
        pad_nxt    = 2'd0;
      end
      unique case (cur_phase)
        PH_HEADER: begin
          if (cur_idx < tgard_pkg::HDR_SIG_BYTES) begin
            plain_nxt = cur_plain && (b == sig_plain);
            rle_nxt   = cur_rle && (b == sig_rle);
          end else if (cur_idx == tgard_pkg::HDR_WIDTH_LO) begin
            width_nxt[7:0] = b;
          end else if (cur_idx == tgard_pkg::HDR_WIDTH_HI) begin
            width_nxt[15:8] = b;
          end else if (cur_idx == tgard_pkg::HDR_HEIGHT_LO) begin
            height_nxt[7:0] = b;
          end else if (cur_idx == tgard_pkg::HDR_HEIGHT_HI) begin
            height_nxt[15:8] = b;
          end else if (cur_idx == tgard_pkg::HDR_DEPTH_INDEX) begin
            depth_nxt = b;
          end
          if (cur_idx < tgard_pkg::HDR_LAST_INDEX) begin
            idx_nxt = cur_idx + 5'd1;
          end else begin
            push                     = 1'b1;
            push_item.image_width    = width_r;
            push_item.image_height   = height_r;
            push_item.bits_per_pixel = depth_r;
            push_item.last           = 1'b1;
            phase_nxt                = PH_DONE;
            if (bad_type) begin
              push_item.kind = tgard_pkg::KIND_BAD_TYPE;
            end else if (bad_depth) begin
              push_item.kind = tgard_pkg::KIND_BAD_DEPTH;
            end else begin
              push_item.kind = tgard_pkg::KIND_HEADER;
              if (!empty_img) begin
                push_item.last = 1'b0;
                phase_nxt      = cur_rle ? PH_PKT_HEAD : PH_PIXEL;
              end
            end
          end
        end
        PH_PKT_HEAD: begin
          if (b < tgard_pkg::RUN_FLAG) begin
            is_run_nxt = 1'b0;
            left_nxt   = b + 8'd1;
          end else begin
            is_run_nxt = 1'b1;
            left_nxt   = b - tgard_pkg::RUN_BIAS;
          end
          phase_nxt = PH_PIXEL;
        end
        PH_PIXEL: begin
          if (!pix_done) begin
            case (bip_r)
              2'd0:    asm_nxt[7:0]   = b;
              2'd1:    asm_nxt[15:8]  = b;
              default: asm_nxt[23:16] = b;
            endcase
            bip_nxt = bip_r + 2'd1;
          end else begin
            // pixels past the image end are dropped by the back end
            push                 = 1'b1;
            push_item.kind       = tgard_pkg::KIND_PIXEL;
            push_item.blue       = asm_r[7:0];
            push_item.green      = asm_r[15:8];
            push_item.red        = is_32 ? asm_r[23:16] : b;
            push_item.alpha      = is_32 ? b : 8'd0;
            push_item.run_length = (rle_r && is_run_r) ? left_r : 8'd1;
            asm_nxt              = 24'd0;
            bip_nxt              = 2'd0;
            if (rle_r) begin
              if (is_run_r) begin
                phase_nxt = PH_PKT_HEAD;
              end else begin
                left_nxt = left_dec;
                if (left_dec == 8'd0) begin
                  phase_nxt = PH_PKT_HEAD;
                end
              end
            end else if (col_inc >= width_r) begin
              col_nxt = 16'd0;
              pad_nxt = is_32 ? 2'd0 : width_r[1:0];
              if (!is_32 && (width_r[1:0] != 2'd0)) begin
                phase_nxt = PH_PAD;
              end
            end else begin
              col_nxt = col_inc;
            end
          end
        end
        PH_PAD: begin
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            phase_nxt = PH_PIXEL;
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      idx_r    <= 5'd0;
      width_r  <= 16'd0;
      height_r <= 16'd0;
      depth_r  <= 8'd0;
      plain_r  <= 1'b1;
      rle_r    <= 1'b1;
      left_r   <= 8'd0;
      is_run_r <= 1'b0;
      asm_r    <= 24'd0;
      bip_r    <= 2'd0;
      col_r    <= 16'd0;
      pad_r    <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      plain_r  <= plain_nxt;
      rle_r    <= rle_nxt;
      left_r   <= left_nxt;
      is_run_r <= is_run_nxt;
      asm_r    <= asm_nxt;
      bip_r    <= bip_nxt;
      col_r    <= col_nxt;
      pad_r    <= pad_nxt;
    end
  end

  `TGARD_CHECK(a_hdr_idx_range, (phase_r == PH_HEADER) |-> (idx_r <= tgard_pkg::HDR_LAST_INDEX), "header index ran past the last header byte")
  `TGARD_CHECK(a_pad_nonzero, (phase_r == PH_PAD) |-> (pad_r != 2'd0), "padding phase with no padding left")

endmodule

// ===== rtl/tgard_queue.sv =====
`timescale 1ns / 1ps
`include "tga_rle_image_decoder_macros.svh"

module tgard_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tgard_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output tgard_pkg::item_t  head_item
);

  localparam int PTR_W = $clog2(tgard_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tgard_pkg::QUEUE_DEPTH + 1);

  tgard_pkg::item_t slot_r [tgard_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(tgard_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_item = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? PTR_W'((wr_r + 1'b1) % tgard_pkg::QUEUE_DEPTH) : wr_r;
    rd_nxt  = pop ? PTR_W'((rd_r + 1'b1) % tgard_pkg::QUEUE_DEPTH) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

  `TGARD_NEVER(a_q_overflow, push && full, "item pushed into a full queue")
  `TGARD_NEVER(a_q_underflow, pop && !not_empty, "item popped from an empty queue")

endmodule

// ===== rtl/tgard_back.sv =====
`timescale 1ns / 1ps
`include "tga_rle_image_decoder_macros.svh"

module tgard_back #(
  parameter int PIXEL_COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tgard_pkg::item_t  q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output tgard_pkg::item_t  out_item
);

  localparam int PB = PIXEL_COUNT_BITS;

  logic [PB-1:0]                    remaining_r, remaining_nxt;
  logic                             out_valid_r, out_valid_nxt;
  tgard_pkg::item_t                 res_r, res_nxt;
  logic [tgard_pkg::PROD_BITS-1:0]  prod;
  logic [tgard_pkg::PROD_BITS-1:0]  prod_hi;
  logic [PB-1:0]                    total;
  logic [PB-1:0]                    req_wide;
  logic [7:0]                       run;
  logic [PB-1:0]                    rem_after;
  logic                             is_pixel;

  assign prod      = tgard_pkg::PROD_BITS'(q_item.image_width * q_item.image_height);
  assign prod_hi   = prod >> PB;
  // pixel total saturates at the counter width
  assign total     = (prod_hi != '0) ? {PB{1'b1}} : prod[PB-1:0];
  assign req_wide  = {{(PB-8){1'b0}}, q_item.run_length};
  assign run       = (req_wide <= remaining_r) ? q_item.run_length : remaining_r[7:0];
  assign rem_after = remaining_r - {{(PB-8){1'b0}}, run};
  assign is_pixel  = (q_item.kind == tgard_pkg::KIND_PIXEL);

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  always_comb begin
    remaining_nxt = remaining_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      res_nxt = q_item;
      if (is_pixel) begin
        // pixels after the image is complete are dropped
        out_valid_nxt      = (remaining_r != '0);
        res_nxt.run_length = run;
        res_nxt.last       = (rem_after == '0);
        if (remaining_r != '0) begin
          remaining_nxt = rem_after;
        end
      end else begin
        out_valid_nxt = 1'b1;
        remaining_nxt = (q_item.kind == tgard_pkg::KIND_HEADER && !q_item.last) ? total : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      remaining_r <= remaining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  `TGARD_CHECK(a_rem_no_grow, (pop && is_pixel) |=> (remaining_r <= $past(remaining_r)), "pixel count grew on a pixel item")
  `TGARD_CHECK(a_run_nonzero, (out_valid_r && res_r.kind == tgard_pkg::KIND_PIXEL) |-> (res_r.run_length != 8'd0), "pixel result with zero run")

endmodule

// ===== rtl/tga_rle_image_decoder.sv =====
`timescale 1ns / 1ps
// a completing header or pixel byte's result goes to the queue, then the output register
// throughput: one file byte per cycle while the queue is not full; the parser, a 2-entry
// queue and the output register let bytes keep flowing while a result waits on out_ready
// reset: synchronous active-low rst_n returns the parser to header byte 0 and empties the
// queue and the output stage; no clearing pass is needed
module tga_rle_image_decoder #(
  parameter int PIXEL_COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_alpha,
  output logic [7:0]  out_run_length,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [7:0]  out_bits_per_pixel,
  output logic        out_last
);

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  tgard_pkg::item_t push_item;
  tgard_pkg::item_t head_item;
  tgard_pkg::item_t res;

  tgard_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  tgard_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  tgard_back #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (res)
  );

  assign out_kind           = res.kind;
  assign out_blue           = res.blue;
  assign out_green          = res.green;
  assign out_red            = res.red;
  assign out_alpha          = res.alpha;
  assign out_run_length     = res.run_length;
  assign out_image_width    = res.image_width;
  assign out_image_height   = res.image_height;
  assign out_bits_per_pixel = res.bits_per_pixel;
  assign out_last           = res.last;

endmodule
